// ----- sv/isrm_pkg.sv -----
// Package for the implicit surface ray marcher: payload types, register codes,
// sequencer states and fixed-point constants. No dependencies.
`default_nettype none
package isrm_pkg;

    localparam int unsigned CfgW = 17;
    localparam logic [16:0] StepCap = 17'd65536;
    // 11.8 in Q16.16, rounded
    localparam logic signed [51:0] FieldConst = 52'sd773325;

    typedef enum logic [1:0] {
        CFG_COARSE_STEP   = 2'd0,
        CFG_FINE_STEP     = 2'd1,
        CFG_STEP_BUDGET   = 2'd2,
        CFG_HIT_THRESHOLD = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_ray;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_distance;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
    } t_hit;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PL, ST_PH, ST_PC, ST_SQ, ST_Q4, ST_ACC, ST_DEC, ST_LOOP, ST_FIN
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
        if (v > 70'sh7FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (v < -70'sh80000000) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

// ----- sv/isrm_ray_if.sv -----
// Ray input channel: valid/ready handshake carrying one ray.
// Depends on isrm_pkg.
`default_nettype none
interface isrm_ray_if import isrm_pkg::*; ();
    logic valid;
    logic ready;
    t_ray data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/isrm_hit_if.sv -----
// Hit result channel: valid/ready handshake carrying one march result.
// Depends on isrm_pkg.
`default_nettype none
interface isrm_hit_if import isrm_pkg::*; ();
    logic valid;
    logic ready;
    t_hit data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/isrm_mul.sv -----
// Shared 33x33 signed multiplier with registered product.
// Depends on isrm_pkg only for house consistency of types.
`default_nettype none
module isrm_mul import isrm_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic signed [32:0] i_a,
    input  wire logic signed [32:0] i_b,
    output logic signed [65:0]      o_p
);
    logic signed [65:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// ----- sv/implicit_surface_ray_march.sv -----
// Ray marcher against the tanglecube surface x^4-5x^2+y^4-5y^2+z^4-5z^2+11.8.
// Depends on isrm_pkg, isrm_ray_if, isrm_hit_if and isrm_mul.
//
// Usage: a ray (origin, direction, Q16.16) is transferred on i_ray when ready is
// high; ready is high only while the sequencer is idle. One result per ray is
// offered on o_hit from an output register, so a new ray may start while the
// previous result still waits for its transfer.
// Sequence: all products go through the one shared 33x33 multiplier. The origin
// evaluation runs the square, fourth-power and accumulate states per axis term,
// then the sign decision. Each evaluation on the ray runs the loop state, the
// low, high and commit states per coordinate of the ray point and the square,
// fourth-power and accumulate states per axis term, then the decision; an axis
// term whose square overflows skips its accumulate state. With step_budget B
// there are at most B+1 evaluations on the ray. A hit recomputes the point and
// passes the finishing state; the sequencer returns to idle before the next ray.
// Reset restores the default register values and empties the output register.
// If the receiver stalls, the finished result holds in the output register and a
// ray that completes meanwhile waits in its last state until the register frees.
// The user must write registers via i_cfg_* only while the block is idle (unchecked).
`default_nettype none
module implicit_surface_ray_march import isrm_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [1:0]      i_cfg_idx,
    input  wire logic [CfgW-1:0] i_cfg_data,
    isrm_ray_if.sink             i_ray,
    isrm_hit_if.source           o_hit
);
    logic [16:0] r_coarse, r_fine, r_thr;
    logic [15:0] r_budget;

    t_state r_state, n_state;
    logic signed [31:0] r_o [3];
    logic signed [31:0] r_d [3];
    logic signed [31:0] r_p [3];
    logic [1:0]  r_ax;
    logic signed [35:0] r_t;
    logic [16:0] r_step;
    logic [15:0] r_count;
    logic        r_fine_mode, r_org, r_final, r_big, r_pos, r_zero;
    logic signed [51:0] r_f;
    logic signed [65:0] r_pacc;
    logic [31:0] r_sq;
    logic        r_ov;
    t_hit        r_out;

    logic signed [32:0] m_a, m_b;
    logic signed [65:0] m_p;

    isrm_mul u_mul (.i_clk(i_clk), .i_a(m_a), .i_b(m_b), .o_p(m_p));

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coarse <= 17'd6554;
            r_fine   <= 17'd66;
            r_budget <= 16'd1000;
            r_thr    <= 17'd328;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_COARSE_STEP:   r_coarse <= i_cfg_data;
                CFG_FINE_STEP:     r_fine   <= i_cfg_data;
                CFG_STEP_BUDGET:   r_budget <= i_cfg_data[15:0];
                CFG_HIT_THRESHOLD: r_thr    <= i_cfg_data;
            endcase
        end
    end

    logic [16:0] cstep, fstep;
    assign cstep = (r_coarse > StepCap) ? StepCap : r_coarse;
    assign fstep = (r_fine > StepCap) ? StepCap : r_fine;

    // datapath helpers
    logic [47:0] sq_full;
    logic        sq_big;
    logic signed [69:0] pt_full, pt_sum;
    logic signed [51:0] term, f_thr;
    logic        crossed;
    assign sq_full = m_p[63:16];
    assign sq_big  = |sq_full[47:32];
    assign pt_full = 70'(r_pacc) + (70'(m_p) <<< 17);
    assign pt_sum  = (pt_full >>> 16) + 70'(r_o[r_ax]);
    assign term    = 52'($signed({4'd0, m_p[63:16]}))
                     - 52'($signed({20'd0, r_sq}) * 52'sd5);
    assign f_thr   = 52'($signed({35'd0, r_thr}));
    // saturated field is huge and positive
    assign crossed = r_pos ? (!r_big && (r_f < f_thr)) : (r_big || (r_f > -f_thr));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_ray.valid) n_state = ST_SQ;
            ST_PL:   n_state = ST_PH;
            ST_PH:   n_state = ST_PC;
            ST_PC: begin
                if (r_ax != 2'd2) n_state = ST_PL;
                else if (r_final) n_state = ST_FIN;
                else n_state = ST_SQ;
            end
            ST_SQ:   n_state = ST_Q4;
            ST_Q4: begin
                if (!sq_big) n_state = ST_ACC;
                else if (r_ax == 2'd2) n_state = ST_DEC;
                else n_state = ST_SQ;
            end
            ST_ACC:  n_state = (r_ax == 2'd2) ? ST_DEC : ST_SQ;
            ST_DEC: begin
                if (r_org) n_state = ST_LOOP;
                else if (crossed && r_fine_mode) n_state = ST_PL;
                else n_state = ST_LOOP;
            end
            ST_LOOP: n_state = (r_count < r_budget) ? ST_PL : ST_FIN;
            ST_FIN:  if (!r_ov || o_hit.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // multiplier operands and handshake outputs
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            ST_PL: begin
                m_a = $signed({16'd0, r_t[16:0]});
                m_b = 33'(r_d[r_ax]);
            end
            ST_PH: begin
                m_a = 33'($signed(r_t[35:17]));
                m_b = 33'(r_d[r_ax]);
            end
            ST_SQ: begin
                m_a = 33'(r_p[r_ax]);
                m_b = 33'(r_p[r_ax]);
            end
            ST_Q4: begin
                m_a = $signed({1'b0, sq_full[31:0]});
                m_b = $signed({1'b0, sq_full[31:0]});
            end
            default: ;
        endcase
    end

    assign i_ray.ready = (r_state == ST_IDLE);
    assign o_hit.valid = r_ov;
    assign o_hit.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_hit.ready) r_ov <= 1'b0;
            if (r_state == ST_FIN && (!r_ov || o_hit.ready)) r_ov <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: if (i_ray.valid) begin
                r_o[0] <= i_ray.data.origin_x;
                r_o[1] <= i_ray.data.origin_y;
                r_o[2] <= i_ray.data.origin_z;
                r_d[0] <= i_ray.data.dir_x;
                r_d[1] <= i_ray.data.dir_y;
                r_d[2] <= i_ray.data.dir_z;
                r_p[0] <= i_ray.data.origin_x;
                r_p[1] <= i_ray.data.origin_y;
                r_p[2] <= i_ray.data.origin_z;
                r_ax        <= 2'd0;
                r_t         <= '0;
                r_step      <= cstep;
                r_count     <= '0;
                r_fine_mode <= 1'b0;
                r_org       <= 1'b1;
                r_final     <= 1'b0;
                r_big       <= 1'b0;
                r_f         <= FieldConst;
            end
            ST_PL: ;
            ST_PH: r_pacc <= m_p;
            ST_PC: begin
                r_p[r_ax] <= sat32(pt_sum);
                r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                r_f   <= FieldConst;
                r_big <= 1'b0;
            end
            ST_SQ: ;
            ST_Q4: begin
                r_sq <= sq_full[31:0];
                if (sq_big) begin
                    r_big <= 1'b1;
                    if (r_ax != 2'd2) r_ax <= r_ax + 2'd1;
                end
            end
            ST_ACC: begin
                r_f <= r_f + term;
                if (r_ax != 2'd2) r_ax <= r_ax + 2'd1;
            end
            ST_DEC: begin
                r_ax <= 2'd0;
                if (r_org) begin
                    r_org  <= 1'b0;
                    r_pos  <= r_big || (r_f > 52'sd0);
                    r_zero <= !r_big && (r_f == 52'sd0);
                end else if (crossed) begin
                    if (!r_fine_mode) begin
                        // back up one coarse step, continue fine; not counted
                        r_t         <= r_t - 36'($signed({1'b0, r_step}));
                        r_step      <= fstep;
                        r_fine_mode <= 1'b1;
                    end else begin
                        r_final <= 1'b1;
                        if (r_pos) r_t <= r_t - 36'($signed({1'b0, r_thr}));
                        else if (!r_zero) r_t <= r_t + 36'($signed({1'b0, r_thr}));
                    end
                end else begin
                    r_count <= r_count + 16'd1;
                end
            end
            ST_LOOP: begin
                r_ax <= 2'd0;
                if (r_count < r_budget) r_t <= r_t + 36'($signed({1'b0, r_step}));
            end
            ST_FIN: if (!r_ov || o_hit.ready) begin
                r_out.hit <= r_final;
                r_out.hit_distance <= r_final ? sat32(70'(r_t)) : '0;
                r_out.hit_x <= r_final ? r_p[0] : '0;
                r_out.hit_y <= r_final ? r_p[1] : '0;
                r_out.hit_z <= r_final ? r_p[2] : '0;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire
